>>> sv/isp_pkg.sv
package isp_pkg;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;

	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;

	typedef logic [1:0] rank_t;

	localparam rank_t RANK_NONE = 2'd0;
	localparam rank_t RANK_ADD  = 2'd1;
	localparam rank_t RANK_MUL  = 2'd2;
	localparam rank_t RANK_POW  = 2'd3;

	typedef struct packed {
		logic       push;
		logic       pop;
		logic [7:0] data;
	} stack_cmd_t;

	function automatic rank_t rank_of(input logic [7:0] c);
		rank_t r;
		case (c)
			CH_PLUS, CH_MINUS: r = RANK_ADD;
			CH_STAR, CH_SLASH: r = RANK_MUL;
			CH_CARET:          r = RANK_POW;
			default:           r = RANK_NONE;
		endcase
		return r;
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
		       ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z));
	endfunction

endpackage

>>> sv/infix_to_postfix_converter.sv
// Infix to postfix converter (shunting-yard).
// Input channel sym_valid/sym_ready carries one expression character per item
// (symbol_in) and end_of_expr, set on the last character of an expression.
// Output channel res_valid/res_ready carries postfix characters: symbol_out,
// has_symbol (0 only on a bare end marker), last (final result of an
// expression) and the sticky overflow flag.
// An item is worked on by a two-state sequencer that drives one rank compare
// and the operator stack; the stack moves by one entry per cycle unless a
// stalled output holds it. In ST_WORK each stack entry popped and emitted for
// an item takes a step of its own (a discarded open bracket takes none), and
// waiting on res_ready keeps the item in ST_WORK for longer.
// sym_ready is high only between items. Each result is held in a staging
// register so that last can be set; a result thus goes to the output register
// when the next one is produced or when its item completes.
// A stalled receiver holds the output register and the staging register and
// so pauses the sequencer; no result is lost.
// Reset empties the stack, clears the overflow flag and drops any pending
// result. A push to a full stack is dropped and sets overflow until reset.
module infix_to_postfix_converter
	import isp_pkg::*;
#(
	parameter int STACK_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       sym_valid,
	output logic       sym_ready,
	input  logic [7:0] symbol_in,
	input  logic       end_of_expr,
	output logic       res_valid,
	input  logic       res_ready,
	output logic [7:0] symbol_out,
	output logic       has_symbol,
	output logic       last,
	output logic       overflow
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WORK = 2'b10
	} state_t;

	state_t        state_q;
	logic [7:0]    sym_q;
	logic          end_q;
	logic          flush_q;
	logic          ovf_q;
	logic          hold_v_q;
	logic [7:0]    hold_sym_q;
	logic          out_valid_q;
	logic [7:0]    out_sym_q;
	logic          out_has_q;
	logic          out_last_q;
	logic          out_ovf_q;

	stack_cmd_t    cmd;
	logic [7:0]    stk_top;
	logic          stk_empty;
	logic          stk_full;

	logic          slot_free;
	logic          move_ok;
	logic          emit_in;
	logic          pop_emit;
	logic          do_push;
	logic          set_flush;
	logic          finish;
	logic          new_v;
	logic [7:0]    new_sym;
	logic          ld;
	logic [7:0]    ld_sym;
	logic          ld_has;
	logic          ld_last;

	isp_stack #(
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.top    (stk_top),
		.empty  (stk_empty),
		.full   (stk_full)
	);

	assign slot_free = !out_valid_q || res_ready;
	assign move_ok   = !hold_v_q || slot_free;

	always_comb begin
		emit_in   = 1'b0;
		pop_emit  = 1'b0;
		do_push   = 1'b0;
		set_flush = 1'b0;
		finish    = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
			end
			ST_WORK: begin
				if (!flush_q) begin
					if (is_letter(sym_q)) begin
						if (move_ok) begin
							emit_in   = 1'b1;
							set_flush = 1'b1;
						end
					end else if (sym_q == CH_OPEN) begin
						do_push   = 1'b1;
						set_flush = 1'b1;
					end else if (sym_q == CH_CLOSE) begin
						if (!stk_empty && (stk_top != CH_OPEN)) begin
							pop_emit = move_ok;
						end else begin
							cmd.pop   = !stk_empty;
							set_flush = 1'b1;
						end
					end else begin
						if (!stk_empty && (rank_of(sym_q) <= rank_of(stk_top))) begin
							pop_emit = move_ok;
						end else begin
							do_push   = 1'b1;
							set_flush = 1'b1;
						end
					end
				end else if (end_q && !stk_empty) begin
					pop_emit = move_ok;
				end else if (end_q || hold_v_q) begin
					finish = slot_free;
				end else begin
					finish = 1'b1;
				end
			end
			default: begin
			end
		endcase
		cmd.pop  = cmd.pop | pop_emit;
		cmd.push = do_push && !stk_full;
		cmd.data = sym_q;
	end

	assign new_v   = emit_in || pop_emit;
	assign new_sym = emit_in ? sym_q : stk_top;
	assign ld      = (new_v && hold_v_q) || (finish && (end_q || hold_v_q));
	assign ld_sym  = hold_v_q ? hold_sym_q : '0;
	assign ld_has  = hold_v_q;
	assign ld_last = finish && end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			end_q       <= 1'b0;
			flush_q     <= 1'b0;
			ovf_q       <= 1'b0;
			hold_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (sym_valid) begin
						state_q <= ST_WORK;
						end_q   <= end_of_expr;
						flush_q <= 1'b0;
					end
				end
				ST_WORK: begin
					if (set_flush) begin
						flush_q <= 1'b1;
					end
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (do_push && stk_full) begin
				ovf_q <= 1'b1;
			end
			if (new_v) begin
				hold_v_q <= 1'b1;
			end else if (finish) begin
				hold_v_q <= 1'b0;
			end
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && sym_valid) begin
			sym_q <= symbol_in;
		end
		if (new_v) begin
			hold_sym_q <= new_sym;
		end
		if (ld) begin
			out_sym_q  <= ld_sym;
			out_has_q  <= ld_has;
			out_last_q <= ld_last;
			out_ovf_q  <= ovf_q;
		end
	end

	assign sym_ready  = (state_q == ST_IDLE);
	assign res_valid  = out_valid_q;
	assign symbol_out = out_sym_q;
	assign has_symbol = out_has_q;
	assign last       = out_last_q;
	assign overflow   = out_ovf_q;

endmodule

>>> sv/isp_stack.sv
module isp_stack
	import isp_pkg::*;
#(
	parameter int DEPTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  stack_cmd_t                       cmd,
	output logic [7:0]                       top,
	output logic                             empty,
	output logic                             full
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);

	logic [7:0]    mem [DEPTH];
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_next;
	logic [CW-1:0] rd_full;
	logic [AW-1:0] rd_addr;
	logic [7:0]    top_q;

	always_comb begin
		count_next = count_q;
		if (cmd.push) begin
			count_next = count_q + CW'(1);
		end else if (cmd.pop) begin
			count_next = count_q - CW'(1);
		end
		rd_full = (count_next == '0) ? '0 : count_next - CW'(1);
		rd_addr = rd_full[AW-1:0];
	end

	// hold the entry that will be on top after this cycle, bypassing a push
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[count_q[AW-1:0]] <= cmd.data;
			top_q <= cmd.data;
		end else begin
			top_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	assign top   = top_q;
	assign empty = (count_q == '0);
	assign full  = (count_q == CW'(DEPTH));

endmodule

>>> sv/isp_checker.sv
module isp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       sym_valid,
	input logic       sym_ready,
	input logic [7:0] symbol_in,
	input logic       end_of_expr,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] symbol_out,
	input logic       has_symbol,
	input logic       last,
	input logic       overflow
);

	logic in_fire;

	assign in_fire = sym_valid && sym_ready;

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sym_valid && !sym_ready |=> sym_valid && $stable(symbol_in) && $stable(end_of_expr))
		else $error("input item changed while waiting");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(symbol_out) && $stable(last))
		else $error("result changed while stalled");

	a_bare_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !has_symbol |-> last && (symbol_out == 8'h00))
		else $error("bare end marker without last or with a symbol");

	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && overflow |=> !res_valid || overflow)
		else $error("overflow flag cleared");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !sym_ready)
		else $error("input taken again before item finished");

endmodule

bind infix_to_postfix_converter isp_checker u_isp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.sym_valid   (sym_valid),
	.sym_ready   (sym_ready),
	.symbol_in   (symbol_in),
	.end_of_expr (end_of_expr),
	.res_valid   (res_valid),
	.res_ready   (res_ready),
	.symbol_out  (symbol_out),
	.has_symbol  (has_symbol),
	.last        (last),
	.overflow    (overflow)
);

>>> bench/infix_to_postfix_converter_tb.sv
`timescale 1ns / 100ps

module infix_to_postfix_converter_tb
	import isp_pkg::*;
;

	localparam int STACK_DEPTH = 32;
	localparam int DRAIN_CYCLES = STACK_DEPTH + 8;
	localparam int LONG_HOLD = 400;

	typedef struct packed {
		logic [7:0] sym;
		logic       has;
		logic       lst;
		logic       ovf;
	} postfix_res_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       sym_valid = 1'b0;
	logic       sym_ready;
	logic [7:0] symbol_in = 8'h00;
	logic       end_of_expr = 1'b0;
	logic       res_valid;
	logic       res_ready = 1'b0;
	logic [7:0] symbol_out;
	logic       has_symbol;
	logic       last;
	logic       overflow;

	postfix_res_t postfix_q[$];
	logic [7:0]   shadow_stack [STACK_DEPTH];
	int           shadow_count = 0;
	logic         shadow_ovf = 1'b0;

	int   mismatch_count = 0;
	int   items_sent = 0;
	logic src_idle_en = 1'b1;
	logic sink_idle_en = 1'b1;
	int   hold_requests = 0;
	int   hold_served = 0;
	int   ready_idle = 0;

	infix_to_postfix_converter #(
		.STACK_DEPTH(STACK_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.sym_valid(sym_valid),
		.sym_ready(sym_ready),
		.symbol_in(symbol_in),
		.end_of_expr(end_of_expr),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.symbol_out(symbol_out),
		.has_symbol(has_symbol),
		.last(last),
		.overflow(overflow)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int op_rank(input logic [7:0] c);
		case (c)
			CH_PLUS, CH_MINUS: return 1;
			CH_STAR, CH_SLASH: return 2;
			CH_CARET:          return 3;
			default:           return -1;
		endcase
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
	endfunction

	function automatic void push_op(input logic [7:0] c);
		if (shadow_count >= STACK_DEPTH) begin
			shadow_ovf = 1'b1;
		end else begin
			shadow_stack[shadow_count] = c;
			shadow_count++;
		end
	endfunction

	function automatic postfix_res_t pop_op();
		postfix_res_t r;
		shadow_count--;
		r.sym = shadow_stack[shadow_count];
		r.has = 1'b1;
		r.lst = 1'b0;
		r.ovf = 1'b0;
		return r;
	endfunction

	function automatic void convert_symbol(input logic [7:0] c, input logic eoe);
		postfix_res_t step_q[$];
		postfix_res_t r;
		int rk;
		if (is_alpha(c)) begin
			r.sym = c;
			r.has = 1'b1;
			r.lst = 1'b0;
			r.ovf = 1'b0;
			step_q.push_back(r);
		end else if (c == CH_OPEN) begin
			push_op(c);
		end else if (c == CH_CLOSE) begin
			while (shadow_count > 0 && shadow_stack[shadow_count - 1] != CH_OPEN)
				step_q.push_back(pop_op());
			if (shadow_count > 0)
				shadow_count--;
		end else begin
			rk = op_rank(c);
			while (shadow_count > 0 && rk <= op_rank(shadow_stack[shadow_count - 1]))
				step_q.push_back(pop_op());
			push_op(c);
		end
		if (eoe) begin
			while (shadow_count > 0)
				step_q.push_back(pop_op());
			if (step_q.size() == 0) begin
				r = '0;
				step_q.push_back(r);
			end
			step_q[step_q.size() - 1].lst = 1'b1;
		end
		foreach (step_q[k]) begin
			step_q[k].ovf = shadow_ovf;
			postfix_q.push_back(step_q[k]);
		end
	endfunction

	task automatic send_item(input logic [7:0] c, input logic eoe);
		if (src_idle_en && $urandom_range(0, 4) == 0) begin
			sym_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		sym_valid <= 1'b1;
		symbol_in <= c;
		end_of_expr <= eoe;
		@(posedge clk);
		while (!sym_ready)
			@(posedge clk);
		convert_symbol(c, eoe);
		items_sent++;
	endtask

	task automatic drain_results();
		sym_valid <= 1'b0;
		while (postfix_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] rand_letter();
		if ($urandom_range(0, 1))
			return CH_UPPER_A + 8'($urandom_range(0, 25));
		return CH_LOWER_A + 8'($urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] rand_operator();
		case ($urandom_range(0, 4))
			0:       return CH_PLUS;
			1:       return CH_MINUS;
			2:       return CH_STAR;
			3:       return CH_SLASH;
			default: return CH_CARET;
		endcase
	endfunction

	task automatic send_expression(input logic noisy);
		logic [7:0] seq[$];
		int depth;
		int n_opnd;
		logic eoe;
		depth = 0;
		n_opnd = $urandom_range(1, 6);
		for (int i = 0; i < n_opnd; i++) begin
			while ($urandom_range(0, 3) == 0) begin
				seq.push_back(CH_OPEN);
				depth++;
			end
			seq.push_back(rand_letter());
			while (depth > 0 && $urandom_range(0, 2) == 0) begin
				seq.push_back(CH_CLOSE);
				depth--;
			end
			if (i < n_opnd - 1)
				seq.push_back(rand_operator());
		end
		while (depth > 0) begin
			seq.push_back(CH_CLOSE);
			depth--;
		end
		if (noisy) begin
			repeat ($urandom_range(1, 2))
				seq[$urandom_range(0, seq.size() - 1)] = 8'($urandom_range(0, 255));
		end
		for (int i = 0; i < seq.size(); i++) begin
			eoe = (i == seq.size() - 1) || (noisy && $urandom_range(0, 7) == 0);
			send_item(seq[i], eoe);
		end
	endtask

	task automatic run_expressions(input int n_items);
		int stop_at;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at)
			send_expression($urandom_range(0, 3) == 0);
	endtask

	task automatic test_directed();
		logic [7:0] chain[$];
		// bare end marker on an empty stack
		send_item(CH_CLOSE, 1'b1);
		chain = '{CH_UPPER_A, CH_PLUS, CH_LOWER_Z, CH_STAR, CH_UPPER_Z, CH_CARET, CH_LOWER_A,
			CH_SLASH, CH_OPEN, 8'h62, CH_MINUS, 8'h63, CH_CLOSE};
		foreach (chain[i])
			send_item(chain[i], 1'b0);
		// close without open pops the rest
		send_item(CH_CLOSE, 1'b0);
		// unranked byte pops the open bracket too
		send_item(CH_OPEN, 1'b0);
		send_item(CH_PLUS, 1'b0);
		send_item(8'h30, 1'b0);
		send_item(CH_CLOSE, 1'b0);
		send_item(CH_CLOSE, 1'b1);
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b1);
		drain_results();
	endtask

	task automatic test_random();
		run_expressions(100);
		drain_results();
	endtask

	task automatic test_receiver_hold();
		hold_requests <= hold_requests + 1;
		run_expressions(40);
		drain_results();
	endtask

	task automatic test_sender_pause();
		send_expression(1'b0);
		drain_results();
		send_expression(1'b0);
		drain_results();
	endtask

	task automatic test_overflow();
		repeat (STACK_DEPTH + 2)
			send_item(CH_OPEN, 1'b0);
		send_item(8'h78, 1'b1);
		drain_results();
	endtask

	task automatic test_full_rate();
		src_idle_en = 1'b0;
		sink_idle_en <= 1'b0;
		run_expressions(40);
		drain_results();
	endtask

	always @(posedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served <= hold_requests;
			ready_idle <= LONG_HOLD;
			res_ready <= 1'b0;
		end else if (ready_idle > 0) begin
			ready_idle <= ready_idle - 1;
			res_ready <= 1'b0;
		end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
			ready_idle <= $urandom_range(0, 11);
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
		end
	end

	task automatic report_mismatch(input string what, input postfix_res_t want,
		input postfix_res_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t %s: expected sym=%h has=%b last=%b ovf=%b, got sym=%h has=%b last=%b ovf=%b",
				$realtime, what, want.sym, want.has, want.lst, want.ovf,
				got.sym, got.has, got.lst, got.ovf);
	endtask

	always @(posedge clk) begin : res_monitor
		postfix_res_t got;
		postfix_res_t want;
		if (arst_n && res_valid && res_ready) begin
			got.sym = symbol_out;
			got.has = has_symbol;
			got.lst = last;
			got.ovf = overflow;
			if (postfix_q.size() == 0) begin
				report_mismatch("unexpected item", '0, got);
			end else begin
				want = postfix_q.pop_front();
				if (got.sym !== want.sym || got.has !== want.has ||
				    got.lst !== want.lst || got.ovf !== want.ovf)
					report_mismatch("item mismatch", want, got);
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		test_receiver_hold();
		test_sender_pause();
		test_overflow();
		test_full_rate();
		if (mismatch_count == 0 && postfix_q.size() == 0) begin
			$display("infix_to_postfix_converter: match");
		end else begin
			$display("infix_to_postfix_converter: mismatch");
		end
		$finish;
	end

	initial begin
		#16ms;
		$display("infix_to_postfix_converter: mismatch");
		$finish;
	end

endmodule
